// ===== rtl/core/upts_pkg.sv =====
// Shared types and constants for the unimodal peak ternary search core.
package upts_pkg;

    localparam int COORD_BITS_DEF = 17;
    localparam int VALUE_BITS_DEF = 33;

    // Reset value of the search_high register
    localparam int unsigned SEARCH_HIGH_RST = 100000;

    // Narrowing stops once the interval is this wide or narrower
    localparam int unsigned SPAN_LIMIT = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_MEAS  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_M1   = 4'b0010,
        PH_M2   = 4'b0100,
        PH_SCAN = 4'b1000
    } t_phase;

endpackage

// ===== rtl/core/upts_in_if.sv =====
// Input channel: start / measurement words.
interface upts_in_if #(
    parameter int VALUE_BITS = upts_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [VALUE_BITS-1:0] measured;

    modport source (output valid, op, measured, input ready);
    modport sink   (input valid, op, measured, output ready);
endinterface

// ===== rtl/core/upts_out_if.sv =====
// Output channel: probe coordinate and peak report words.
interface upts_out_if #(
    parameter int COORD_BITS = upts_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] probe_coord;
    logic                  done_res;
    logic [COORD_BITS-1:0] peak_coord;

    modport source (output valid, probe_coord, done_res, peak_coord, input ready);
    modport sink   (input valid, probe_coord, done_res, peak_coord, output ready);
endinterface

// ===== rtl/core/unimodal_peak_ternary_search_core.sv =====
// Top level of the ternary search core for the peak of a unimodal function.
//
//  channel   dir  handshake      word
//  i_req     in   valid/ready    op, measured
//  o_rsp     out  valid/ready    probe_coord, done_res, peak_coord
//  i_cfg_*   in   write enable   search_high
//
// A word is held in the input register, then the step logic loads its result
// into the result register, which offers it to the sink. A new word is
// accepted every cycle while the sink keeps up; with both registers full,
// input ready follows the sink's ready.
// Reset (i_rst_n low at a clock edge) empties both registers, sets the
// search idle and loads search_high with 100000.
module unimodal_peak_ternary_search_core #(
    parameter int COORD_BITS = upts_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = upts_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    upts_in_if.sink               i_req,
    upts_out_if.source            o_rsp,
    input  logic                  i_cfg_wr_en,
    input  logic [COORD_BITS-1:0] i_cfg_wr_data
);
    logic                  r_in_valid;
    logic                  r_op;
    logic [VALUE_BITS-1:0] r_meas;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_probe;
    logic                  r_done;
    logic [COORD_BITS-1:0] r_peak;

    logic [COORD_BITS-1:0] r_search_high;

    upts_pkg::t_phase      r_phase;
    logic [COORD_BITS-1:0] r_lo;
    logic [COORD_BITS-1:0] r_hi;
    logic [COORD_BITS-1:0] r_third;
    logic [VALUE_BITS-1:0] r_first;
    logic [COORD_BITS-1:0] r_scan;
    logic [COORD_BITS-1:0] r_best_coord;
    logic [VALUE_BITS-1:0] r_best_value;

    upts_pkg::t_phase      n_phase;
    logic [COORD_BITS-1:0] n_lo;
    logic [COORD_BITS-1:0] n_hi;
    logic [COORD_BITS-1:0] n_third;
    logic [VALUE_BITS-1:0] n_first;
    logic [COORD_BITS-1:0] n_scan;
    logic [COORD_BITS-1:0] n_best_coord;
    logic [VALUE_BITS-1:0] n_best_value;
    logic [COORD_BITS-1:0] n_probe;
    logic                  n_done;
    logic [COORD_BITS-1:0] n_peak;

    logic w_accept;
    logic w_advance;

    assign w_advance = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_accept = i_req.valid && i_req.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.probe_coord = r_probe;
    assign o_rsp.done_res    = r_done;
    assign o_rsp.peak_coord  = r_peak;

    upts_step #(
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_phase       (r_phase),
        .i_lo          (r_lo),
        .i_hi          (r_hi),
        .i_third       (r_third),
        .i_first       (r_first),
        .i_scan        (r_scan),
        .i_best_coord  (r_best_coord),
        .i_best_value  (r_best_value),
        .i_search_high (r_search_high),
        .i_op          (r_op),
        .i_meas        (r_meas),
        .o_phase       (n_phase),
        .o_lo          (n_lo),
        .o_hi          (n_hi),
        .o_third       (n_third),
        .o_first       (n_first),
        .o_scan        (n_scan),
        .o_best_coord  (n_best_coord),
        .o_best_value  (n_best_value),
        .o_probe       (n_probe),
        .o_done        (n_done),
        .o_peak        (n_peak)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.op;
            r_meas <= i_req.measured;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_probe <= n_probe;
            r_done  <= n_done;
            r_peak  <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_high <= COORD_BITS'(upts_pkg::SEARCH_HIGH_RST);
        end else if (i_cfg_wr_en) begin
            r_search_high <= i_cfg_wr_data;
        end
    end

    // Search state: advance once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= upts_pkg::PH_IDLE;
            r_lo         <= '0;
            r_hi         <= '0;
            r_third      <= '0;
            r_first      <= '0;
            r_scan       <= '0;
            r_best_coord <= '0;
            r_best_value <= '0;
        end else if (w_advance) begin
            r_phase      <= n_phase;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_third      <= n_third;
            r_first      <= n_first;
            r_scan       <= n_scan;
            r_best_coord <= n_best_coord;
            r_best_value <= n_best_value;
        end
    end

`ifndef SYNTHESIS
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("lower bound above upper bound");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == upts_pkg::PH_SCAN) |-> (r_scan >= r_lo && r_scan <= r_hi))
        else $error("scan index outside interval");

    a_done_no_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_probe == '0))
        else $error("probe issued with done word");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded");
`endif
endmodule

// ===== rtl/core/upts_div3.sv =====
// Unsigned divide by three through a reciprocal multiply.
module upts_div3 #(
    parameter int W = upts_pkg::COORD_BITS_DEF
) (
    input  logic [W-1:0] i_x,
    output logic [W-1:0] o_q
);
    // ceil(2^(W+2) / 3): exact floor quotient for every W-bit operand
    localparam logic [W+2:0] POW        = {1'b1, {(W+2){1'b0}}};
    localparam logic [W+2:0] RECIP_FULL = (POW + (W+3)'(2)) / (W+3)'(3);
    localparam logic [W:0]   RECIP      = RECIP_FULL[W:0];

    logic [2*W:0] w_prod;

    assign w_prod = (2*W+1)'(RECIP) * (2*W+1)'(i_x);
    assign o_q    = {1'b0, w_prod[2*W:W+2]};
endmodule

// ===== rtl/core/upts_step.sv =====
// Next-state and result logic for one search word.
module upts_step #(
    parameter int COORD_BITS = upts_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = upts_pkg::VALUE_BITS_DEF
) (
    input  upts_pkg::t_phase        i_phase,
    input  logic [COORD_BITS-1:0]   i_lo,
    input  logic [COORD_BITS-1:0]   i_hi,
    input  logic [COORD_BITS-1:0]   i_third,
    input  logic [VALUE_BITS-1:0]   i_first,
    input  logic [COORD_BITS-1:0]   i_scan,
    input  logic [COORD_BITS-1:0]   i_best_coord,
    input  logic [VALUE_BITS-1:0]   i_best_value,
    input  logic [COORD_BITS-1:0]   i_search_high,
    input  logic                    i_op,
    input  logic [VALUE_BITS-1:0]   i_meas,
    output upts_pkg::t_phase        o_phase,
    output logic [COORD_BITS-1:0]   o_lo,
    output logic [COORD_BITS-1:0]   o_hi,
    output logic [COORD_BITS-1:0]   o_third,
    output logic [VALUE_BITS-1:0]   o_first,
    output logic [COORD_BITS-1:0]   o_scan,
    output logic [COORD_BITS-1:0]   o_best_coord,
    output logic [VALUE_BITS-1:0]   o_best_value,
    output logic [COORD_BITS-1:0]   o_probe,
    output logic                    o_done,
    output logic [COORD_BITS-1:0]   o_peak
);
    logic [COORD_BITS-1:0] w_m1;
    logic [COORD_BITS-1:0] w_m2;
    logic [COORD_BITS-1:0] w_lo_nxt;
    logic [COORD_BITS-1:0] w_hi_nxt;
    logic [COORD_BITS-1:0] w_span;
    logic [COORD_BITS-1:0] w_new_third;
    logic                  w_round;

    // Probe points of the current interval from the stored third
    assign w_m1 = i_lo + i_third;
    assign w_m2 = i_hi - i_third;

    // New bounds: reload on start, narrow after the second probe
    always_comb begin
        w_lo_nxt = i_lo;
        w_hi_nxt = i_hi;
        if (i_op == upts_pkg::OP_START) begin
            w_lo_nxt = '0;
            w_hi_nxt = i_search_high;
        end else if (i_phase == upts_pkg::PH_M2) begin
            if (i_first < i_meas) begin
                w_lo_nxt = w_m1;
            end else begin
                w_hi_nxt = w_m2;
            end
        end
    end

    assign w_span = w_hi_nxt - w_lo_nxt;

    upts_div3 #(
        .W (COORD_BITS)
    ) u_div3 (
        .i_x (w_span),
        .o_q (w_new_third)
    );

    assign o_third = w_new_third;

    always_comb begin
        o_phase      = i_phase;
        o_lo         = w_lo_nxt;
        o_hi         = w_hi_nxt;
        o_first      = i_first;
        o_scan       = i_scan;
        o_best_coord = i_best_coord;
        o_best_value = i_best_value;
        o_probe      = '0;
        o_done       = 1'b0;
        o_peak       = '0;
        w_round      = 1'b0;

        if (i_op == upts_pkg::OP_START) begin
            w_round = 1'b1;
        end else begin
            unique case (i_phase)
                upts_pkg::PH_M1: begin
                    o_first = i_meas;
                    o_phase = upts_pkg::PH_M2;
                    o_probe = w_m2;
                end
                upts_pkg::PH_M2: begin
                    w_round = 1'b1;
                end
                upts_pkg::PH_SCAN: begin
                    if (i_scan == i_lo || i_meas > i_best_value) begin
                        o_best_value = i_meas;
                        o_best_coord = i_scan;
                    end
                    if (i_scan >= i_hi) begin
                        o_phase = upts_pkg::PH_IDLE;
                        o_done  = 1'b1;
                        o_peak  = (i_scan == i_lo || i_meas > i_best_value) ?
                                  i_scan : i_best_coord;
                    end else begin
                        o_scan  = i_scan + 1'b1;
                        o_probe = i_scan + 1'b1;
                    end
                end
                default: begin
                    // measurement while idle: drop it
                end
            endcase
        end

        // Pick the next probe from the new bounds
        if (w_round) begin
            if (w_span > COORD_BITS'(upts_pkg::SPAN_LIMIT)) begin
                o_phase = upts_pkg::PH_M1;
                o_probe = w_lo_nxt + w_new_third;
            end else begin
                o_phase = upts_pkg::PH_SCAN;
                o_scan  = w_lo_nxt;
                o_probe = w_lo_nxt;
            end
        end
    end
endmodule
